### design/scissor_rect_stack_top_defines.svh
// assertion macros shared by the scissor rectangle stack design files
// no dependencies; every macro samples on aclk and is disabled during reset
`ifndef SCISSOR_RECT_STACK_TOP_DEFINES_SVH
`define SCISSOR_RECT_STACK_TOP_DEFINES_SVH

// condition in this cycle implies a check in the same cycle
`define SRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies a check in the next cycle
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/srs_pkg.sv
// types and constants for the scissor rectangle stack
// no dependencies; used by srs_step and scissor_rect_stack_top
package srs_pkg;

    localparam int VP_W   = 14;
    localparam int EDGE_W = 16;

    // action codes carried in the request
    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_PUSH_ISECT = 2'd1,
        ACT_POP        = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    // configuration register indexes
    localparam logic CFG_VP_WIDTH  = 1'b0;
    localparam logic CFG_VP_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [EDGE_W-1:0] bottom;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] left;
    } rect_t;

    typedef struct packed {
        logic wr_en;
        logic refused;
    } step_ctl_t;

    typedef struct packed {
        logic               overflow;
        logic [4:0]         level;
        logic [15:0]        h;
        logic [15:0]        w;
        logic signed [16:0] y;
        logic signed [15:0] x;
    } result_t;

endpackage

### design/srs_ram.sv
// generic single write port ram with one registered read port
// no dependencies; holds every pushed rectangle, the top one included, which is also cached
module srs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/srs_step.sv
// next-state and result logic for one stack request
// depends on srs_pkg; purely combinational, sits between the request and result registers
module srs_step #(
    parameter int STACK_DEPTH = 16,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  srs_pkg::action_t          action,
    input  srs_pkg::rect_t            rect_in,
    input  logic [CW-1:0]             count,
    input  srs_pkg::rect_t            top_cache,
    input  srs_pkg::rect_t            below,
    input  logic [srs_pkg::VP_W-1:0]  vp_width,
    input  logic [srs_pkg::VP_W-1:0]  vp_height,
    output logic [CW-1:0]             count_next,
    output srs_pkg::rect_t            top_next,
    output srs_pkg::rect_t            push_rect,
    output srs_pkg::step_ctl_t        ctl,
    output srs_pkg::result_t          result
);
    import srs_pkg::*;

    rect_t base;
    rect_t cur;
    rect_t isect;
    rect_t shown;
    logic  is_push;
    logic  full;

    // viewport base entry, taken live from config
    always_comb begin
        base.left   = '0;
        base.top    = '0;
        base.right  = {2'b00, vp_width};
        base.bottom = {2'b00, vp_height};
    end

    assign cur = (count == '0) ? base : top_cache;

    // optional intersection with the current top
    always_comb begin
        isect = rect_in;
        if (action == ACT_PUSH_ISECT) begin
            if (cur.left > rect_in.left)     isect.left   = cur.left;
            if (cur.top > rect_in.top)       isect.top    = cur.top;
            if (cur.right < rect_in.right)   isect.right  = cur.right;
            if (cur.bottom < rect_in.bottom) isect.bottom = cur.bottom;
        end
    end

    // clamp right up to left and bottom up to top
    always_comb begin
        push_rect = isect;
        if (isect.right < isect.left)  push_rect.right  = isect.left;
        if (isect.bottom < isect.top)  push_rect.bottom = isect.top;
    end

    assign is_push     = (action == ACT_PUSH) || (action == ACT_PUSH_ISECT);
    assign full        = (count >= CW'(STACK_DEPTH));
    assign ctl.wr_en   = is_push && !full;
    assign ctl.refused = is_push && full;

    // stack pointer and cached top update
    always_comb begin
        count_next = count;
        top_next   = top_cache;
        unique case (action)
            ACT_PUSH, ACT_PUSH_ISECT: begin
                if (!full) begin
                    count_next = count + CW'(1);
                    top_next   = push_rect;
                end
            end
            ACT_POP: begin
                if (count != '0) begin
                    count_next = count - CW'(1);
                    top_next   = below;
                end
            end
            ACT_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count;
            end
        endcase
    end

    assign shown = (count_next == '0) ? base : top_next;

    // scissor box of the new top entry
    always_comb begin
        result.x        = shown.left;
        result.y        = {3'b000, vp_height} - {shown.bottom[EDGE_W-1], shown.bottom};
        result.w        = shown.right - shown.left;
        result.h        = shown.bottom - shown.top;
        result.level    = 5'(count_next);
        result.overflow = ctl.refused;
    end

endmodule

### design/scissor_rect_stack_top.sv
// scissor rectangle stack: requests pass the request register, then the result register
// one request per cycle unless m_tready stalls the result; the top entry is cached in a
// register and the entry below it is prefetched from the ram, so a pop never waits
// reset (aresetn low, synchronous) empties the stack and sets the viewport to 640 x 480
// depends on srs_pkg, srs_step, srs_ram and scissor_rect_stack_top_defines.svh
module scissor_rect_stack_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [srs_pkg::VP_W-1:0] cfg_wdata,
    // request channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [63:0]              s_tdata,  // rect_left, rect_top, rect_right, rect_bottom
    input  logic [1:0]               s_tuser,  // action
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [71:0]              m_tdata   // scissor_x, scissor_y, scissor_w, scissor_h,
                                               // stack_level, overflow, zero pad
);
    import srs_pkg::*;
    `include "scissor_rect_stack_top_defines.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW = $bits(rect_t);

    logic [VP_W-1:0] vp_width_reg;
    logic [VP_W-1:0] vp_height_reg;
    logic            in_valid_reg;
    action_t         in_action_reg;
    rect_t           in_rect_reg;
    logic            m_valid_reg;
    result_t         res_reg;
    logic [CW-1:0]   count_reg;
    rect_t           top_reg;

    logic            advance;
    logic [CW-1:0]   count_next;
    rect_t           top_next;
    rect_t           push_rect;
    step_ctl_t       ctl;
    result_t         result;
    logic [RW-1:0]   below_raw;
    rect_t           below;
    logic [CW-1:0]   count_eff;
    logic [CW:0]     rd_idx;
    logic [AW-1:0]   rd_addr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_width_reg  <= VP_W'(640);
            vp_height_reg <= VP_W'(480);
        end else if (cfg_we) begin
            if (cfg_index == CFG_VP_WIDTH) begin
                vp_width_reg <= cfg_wdata;
            end else begin
                vp_height_reg <= cfg_wdata;
            end
        end
    end

    // a request moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_rect_reg   <= rect_t'(s_tdata);
        end
    end

    // stack step
    srs_step #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_step (
        .action     (in_action_reg),
        .rect_in    (in_rect_reg),
        .count      (count_reg),
        .top_cache  (top_reg),
        .below      (below),
        .vp_width   (vp_width_reg),
        .vp_height  (vp_height_reg),
        .count_next (count_next),
        .top_next   (top_next),
        .push_rect  (push_rect),
        .ctl        (ctl),
        .result     (result)
    );

    // stack pointer and cached top entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (advance) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            top_reg <= top_next;
        end
    end

    // prefetch the entry below the top for the count that holds after this edge
    assign count_eff = advance ? count_next : count_reg;
    assign rd_idx    = {1'b0, count_eff} - (CW + 1)'(2);
    assign rd_addr   = (count_eff < CW'(2)) ? '0 : rd_idx[AW-1:0];
    assign below     = rect_t'(below_raw);

    srs_ram #(
        .WIDTH (RW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (advance && ctl.wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (push_rect),
        .rd_addr (rd_addr),
        .rd_data (below_raw)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    // checks
    `SRS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(STACK_DEPTH),
        "stack pointer beyond stack depth")
    `SRS_ASSERT_NOW(a_write_in_range, advance && ctl.wr_en, count_reg < CW'(STACK_DEPTH),
        "push written past the stack end")
    `SRS_ASSERT_NEXT(a_refused_keeps, advance && ctl.refused, $stable(count_reg),
        "refused push changed the stack pointer")
    `SRS_ASSERT_NEXT(a_idle_keeps, !advance, $stable(count_reg),
        "stack pointer moved without a request")

endmodule
